[rtl/hrqc_pkg.sv]
package hrqc_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int MAX_KEYS_DEF    = 6;
    localparam int KEY_SLOTS       = 6;
    localparam int LEVEL_MAX       = 15;

    localparam logic [1:0] OP_ENQUEUE  = 2'd0;
    localparam logic [1:0] OP_SEND     = 2'd1;
    localparam logic [1:0] OP_COMPLETE = 2'd2;

    localparam logic KIND_CONSUMER = 1'b0;
    localparam logic KIND_KEYBOARD = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        report_kind;
        logic [15:0] report_value;
    } in_item_t;

    typedef struct packed {
        logic        sent;
        logic        sent_kind;
        logic [15:0] consumer_usage;
        logic [7:0]  key_0;
        logic [7:0]  key_1;
        logic [7:0]  key_2;
        logic [7:0]  key_3;
        logic [7:0]  key_4;
        logic [7:0]  key_5;
        logic [2:0]  key_count;
        logic [3:0]  queue_level;
    } out_item_t;

    // classified command handed from front to back
    typedef struct packed {
        logic        push;
        logic        send;
        logic        complete;
        logic        kind;
        logic [15:0] value;
    } cmd_t;

endpackage

[rtl/hrqc_front.sv]
module hrqc_front
    import hrqc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    output logic     item_ready,
    input  in_item_t item,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    cmd_t       decoded;
    logic       push_en;
    logic       pop_en;

    always_comb
    begin
        decoded.push     = (item.opcode == OP_ENQUEUE);
        decoded.send     = (item.opcode == OP_SEND);
        decoded.complete = (item.opcode == OP_COMPLETE);
        decoded.kind     = item.report_kind;
        decoded.value    = item.report_value;
    end

    assign item_ready = (cnt_reg != 2'd2);
    assign cmd_valid  = (cnt_reg != 2'd0);
    assign cmd        = slot_reg[rd_ptr_reg];
    assign push_en    = item_valid && item_ready;
    assign pop_en     = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push_en)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop_en)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push_en && !pop_en)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop_en && !push_en)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

[rtl/hrqc_back.sv]
module hrqc_back
    import hrqc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_KEYS    = MAX_KEYS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PW:0] DEPTH_V = (PW + 1)'(QUEUE_DEPTH);
    localparam logic [2:0]  MAX_K   = 3'(MAX_KEYS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_POP,
        ST_WAIT,
        ST_COLLECT,
        ST_RESULT
    } state_t;

    state_t      state_reg,      state_next;
    logic [PW-1:0] head_reg,     head_next;
    logic [PW-1:0] tail_reg,     tail_next;
    logic        busy_reg,       busy_next;
    logic [16:0] push_data_reg,  push_data_next;
    logic        sent_reg,       sent_next;
    logic        kind_reg,       kind_next;
    logic [15:0] usage_reg,      usage_next;
    logic [7:0]  keys_reg [KEY_SLOTS];
    logic [7:0]  keys_next [KEY_SLOTS];
    logic [2:0]  idx_reg,        idx_next;
    logic        out_valid_reg,  out_valid_next;
    out_item_t   out_data_reg,   out_data_next;

    logic [16:0] ring_mem [QUEUE_DEPTH];
    logic [16:0] rd_data_reg;
    logic        wr_en;
    logic        empty;
    logic [PW:0] lvl_full;
    logic [3:0]  lvl_sat;
    logic [7:0]  last_key;
    logic [2:0]  idx_inc;
    logic        take;
    logic [PW-1:0] tail_adv;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if ({1'b0, p} == DEPTH_V - 1'b1)
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign empty    = (head_reg == tail_reg);
    assign last_key = keys_reg[idx_reg];
    assign idx_inc  = idx_reg + 3'd1;
    assign tail_adv = ring_next(tail_reg);
    assign take     = (last_key != 8'd0) && !empty && (idx_inc < MAX_K)
                      && (rd_data_reg[16] == KIND_KEYBOARD)
                      && (rd_data_reg[15:0] != 16'd0);

    always_comb
    begin
        if (tail_reg >= head_reg)
        begin
            lvl_full = {1'b0, tail_reg} - {1'b0, head_reg};
        end
        else
        begin
            lvl_full = {1'b0, tail_reg} + DEPTH_V - {1'b0, head_reg};
        end
        if (8'(lvl_full) > 8'(LEVEL_MAX))
        begin
            lvl_sat = 4'(LEVEL_MAX);
        end
        else
        begin
            lvl_sat = 4'(lvl_full);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ring_mem[tail_reg] <= push_data_reg;
        end
        rd_data_reg <= ring_mem[head_reg];
    end

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        busy_next      = busy_reg;
        push_data_next = push_data_reg;
        sent_next      = sent_reg;
        kind_next      = kind_reg;
        usage_next     = usage_reg;
        keys_next      = keys_reg;
        idx_next       = idx_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !result_ready;
        cmd_ready      = 1'b0;
        wr_en          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && !out_valid_reg)
                begin
                    cmd_ready  = 1'b1;
                    sent_next  = 1'b0;
                    kind_next  = KIND_CONSUMER;
                    usage_next = 16'd0;
                    idx_next   = 3'd0;
                    for (int k = 0; k < KEY_SLOTS; k++)
                    begin
                        keys_next[k] = 8'd0;
                    end
                    if (cmd.push)
                    begin
                        push_data_next = {cmd.kind, cmd.value};
                        state_next     = ST_PUSH;
                    end
                    else if (cmd.complete)
                    begin
                        busy_next  = 1'b0;
                        state_next = ST_RESULT;
                    end
                    else if (cmd.send && !busy_reg && !empty)
                    begin
                        busy_next  = 1'b1;
                        sent_next  = 1'b1;
                        state_next = ST_POP;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
            end
            ST_POP:
            begin
                head_next = ring_next(head_reg);
                if (rd_data_reg[16] == KIND_CONSUMER)
                begin
                    usage_next = rd_data_reg[15:0];
                    if (rd_data_reg[15:0] != 16'd0)
                    begin
                        push_data_next = {KIND_CONSUMER, 16'd0};
                        state_next     = ST_PUSH;
                    end
                    else
                    begin
                        state_next = ST_RESULT;
                    end
                end
                else
                begin
                    kind_next    = KIND_KEYBOARD;
                    keys_next[0] = rd_data_reg[7:0];
                    state_next   = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_COLLECT;
            end
            ST_COLLECT:
            begin
                if (take)
                begin
                    keys_next[idx_inc] = rd_data_reg[7:0];
                    idx_next           = idx_inc;
                    head_next          = ring_next(head_reg);
                    state_next         = ST_WAIT;
                end
                else if (last_key != 8'd0)
                begin
                    push_data_next = {KIND_KEYBOARD, 16'd0};
                    state_next     = ST_PUSH;
                end
                else
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_PUSH:
            begin
                wr_en     = 1'b1;
                tail_next = tail_adv;
                if (tail_adv == head_reg)
                begin
                    head_next = ring_next(head_reg);
                end
                state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                out_valid_next               = 1'b1;
                out_data_next.sent           = sent_reg;
                out_data_next.sent_kind      = kind_reg;
                out_data_next.consumer_usage = usage_reg;
                out_data_next.key_0          = keys_reg[0];
                out_data_next.key_1          = keys_reg[1];
                out_data_next.key_2          = keys_reg[2];
                out_data_next.key_3          = keys_reg[3];
                out_data_next.key_4          = keys_reg[4];
                out_data_next.key_5          = keys_reg[5];
                out_data_next.key_count      = (keys_reg[0] == 8'd0) ? 3'd0 : idx_inc;
                out_data_next.queue_level    = lvl_sat;
                state_next                   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            busy_reg      <= 1'b0;
            push_data_reg <= '0;
            sent_reg      <= 1'b0;
            kind_reg      <= 1'b0;
            usage_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            for (int k = 0; k < KEY_SLOTS; k++)
            begin
                keys_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            busy_reg      <= busy_next;
            push_data_reg <= push_data_next;
            sent_reg      <= sent_next;
            kind_reg      <= kind_next;
            usage_reg     <= usage_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
            keys_reg      <= keys_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

endmodule

[rtl/hid_report_queue_coalescer_core.sv]
// HID report queue with keyboard coalescing.
// Input channel (item_valid/item_ready/item): enqueue a report, offer a send
// slot, or signal that the previous transfer completed. Every item produces
// exactly one result on the output channel (result_valid/result_ready/result).
// A two-entry command queue decouples acceptance from execution, so items are
// taken while the sequencer is busy or a result is waiting.
// A keyboard send coalesces up to MAX_KEYS queued keyboard reports (6 by default).
// Each ring read passes through the registered memory read (ST_WAIT) and a
// decision state (ST_COLLECT), which sets the per-key cost of coalescing.
// The sequencer runs one command at a time; no new command starts while a
// result waits.
// Reset clears pointers, the outstanding-transfer flag and both channels;
// ring contents are not cleared and only written entries are ever read.
// If the receiver stalls, the result is held and the sequencer waits; the
// command queue keeps taking items until both of its slots are full.
module hid_report_queue_coalescer_core
    import hrqc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int MAX_KEYS    = MAX_KEYS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_ready,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    hrqc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    hrqc_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .MAX_KEYS    (MAX_KEYS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

[rtl/hrqc_checker.sv]
module hrqc_checker
    import hrqc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      result_valid,
    input logic      result_ready,
    input out_item_t result
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.sent |->
            !result.sent_kind && result.consumer_usage == 16'd0
            && result.key_count == 3'd0 && result.key_0 == 8'd0)
        else $error("fields not zero when nothing sent");

    a_consumer_no_keys: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sent && !result.sent_kind |->
            result.key_count == 3'd0 && result.key_0 == 8'd0)
        else $error("keys present in consumer report");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.sent_kind |->
            result.consumer_usage == 16'd0 && result.key_count <= 3'(KEY_SLOTS)
            && ((result.key_count == 3'd0) == (result.key_0 == 8'd0)))
        else $error("keyboard report count inconsistent");

endmodule

bind hid_report_queue_coalescer_core hrqc_checker u_hrqc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

[bench/testbench.sv]
`timescale 1ns / 100ps

module testbench
    import hrqc_pkg::*;
();

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ITEM_TARGET = 1950;
    localparam int QUIET_TAIL  = 150;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      item_valid = 1'b0;
    logic      item_ready;
    in_item_t  item = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    out_item_t result;

    in_item_t  pending_requests[$];
    out_item_t expected_reports[$];

    // shadow of the report ring
    logic [16:0] ring_store [QUEUE_DEPTH_DEF] = '{default: '0};
    int          ring_head = 0;
    int          ring_tail = 0;
    bit          transfer_outstanding = 1'b0;

    int  total_items = 0;
    int  stim_count = 0;
    int  accepted_count = 0;
    int  received_count = 0;
    int  fail_count = 0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  hold_gap = 0;
    bit  idle_on = 1'b1;
    bit  stall_on = 1'b1;

    hid_report_queue_coalescer_core DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #10 clk = ~clk;

    function automatic void ring_push(logic kind, logic [15:0] value);
        ring_store[ring_tail] = {kind, value};
        ring_tail = (ring_tail + 1) % QUEUE_DEPTH_DEF;
        if (ring_tail == ring_head)
            ring_head = (ring_head + 1) % QUEUE_DEPTH_DEF;
    endfunction

    function automatic out_item_t predict_report(in_item_t req);
        out_item_t   rep;
        logic [16:0] entry;
        logic [16:0] next_entry;
        logic [7:0]  keys [KEY_SLOTS];
        int          n;
        int          lvl;
        bit          stop;
        rep = '0;
        n = 0;
        stop = 1'b0;
        for (int k = 0; k < KEY_SLOTS; k++)
            keys[k] = 8'h00;
        case (req.opcode)
            OP_ENQUEUE:
                ring_push(req.report_kind, req.report_value);
            OP_COMPLETE:
                transfer_outstanding = 1'b0;
            OP_SEND:
                if (!transfer_outstanding && ring_head != ring_tail)
                begin
                    entry = ring_store[ring_head];
                    ring_head = (ring_head + 1) % QUEUE_DEPTH_DEF;
                    transfer_outstanding = 1'b1;
                    rep.sent = 1'b1;
                    if (entry[16] == KIND_CONSUMER)
                    begin
                        rep.consumer_usage = entry[15:0];
                        if (entry[15:0] != 16'h0000)
                            ring_push(KIND_CONSUMER, 16'h0000);
                    end
                    else
                    begin
                        rep.sent_kind = KIND_KEYBOARD;
                        keys[0] = entry[7:0];
                        while (!stop && keys[n] != 8'h00 && ring_head != ring_tail
                               && n + 1 < MAX_KEYS_DEF && n + 1 < KEY_SLOTS)
                        begin
                            next_entry = ring_store[ring_head];
                            if (next_entry[16] != KIND_KEYBOARD || next_entry[15:0] == 16'h0000)
                                stop = 1'b1;
                            else
                            begin
                                n++;
                                keys[n] = next_entry[7:0];
                                ring_head = (ring_head + 1) % QUEUE_DEPTH_DEF;
                            end
                        end
                        rep.key_count = (keys[0] == 8'h00) ? 3'd0 : 3'(n + 1);
                        if (keys[n] != 8'h00)
                            ring_push(KIND_KEYBOARD, 16'h0000);
                    end
                end
            default:
                ;
        endcase
        rep.key_0 = keys[0];
        rep.key_1 = keys[1];
        rep.key_2 = keys[2];
        rep.key_3 = keys[3];
        rep.key_4 = keys[4];
        rep.key_5 = keys[5];
        lvl = (ring_tail + QUEUE_DEPTH_DEF - ring_head) % QUEUE_DEPTH_DEF;
        if (lvl > LEVEL_MAX)
            lvl = LEVEL_MAX;
        rep.queue_level = 4'(lvl);
        return rep;
    endfunction

    task automatic check_field(string field, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", field, want, got);
            fail_count++;
        end
    endtask

    task automatic add_item(logic [1:0] op, logic kind, logic [15:0] value);
        in_item_t req;
        req.opcode = op;
        req.report_kind = kind;
        req.report_value = value;
        pending_requests.push_back(req);
        if (op != OP_UNUSED)
            stim_count++;
    endtask

    task automatic add_send_complete(int pairs);
        repeat (pairs)
        begin
            add_item(OP_SEND, 1'($urandom), 16'($urandom));
            add_item(OP_COMPLETE, 1'($urandom), 16'($urandom));
        end
    endtask

    function automatic logic [15:0] key_value();
        case ($urandom_range(0, 9))
            0: return 16'h0000;
            1: return {8'($urandom_range(1, 255)), 8'h00};
            default: return {($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00,
                             8'($urandom_range(1, 255))};
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                expected_reports.push_back(predict_report(item));
                accepted_count++;
                if ($urandom_range(0, 59) == 0)
                    idle_on = !idle_on;
                if (accepted_count > total_items - QUIET_TAIL)
                    idle_on = 1'b0;
            end
            if (!item_valid || item_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0)
                begin
                    item <= pending_requests.pop_front();
                    item_valid <= 1'b1;
                    if (idle_on && $urandom_range(0, 3) == 0)
                        send_gap = $urandom_range(1, 7);
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                out_item_t want;
                received_count++;
                if (expected_reports.size() == 0)
                begin
                    $error("result transfer with nothing expected");
                    fail_count++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("sent", 16'(want.sent), 16'(result.sent));
                    check_field("sent_kind", 16'(want.sent_kind), 16'(result.sent_kind));
                    check_field("consumer_usage", want.consumer_usage, result.consumer_usage);
                    check_field("key_0", 16'(want.key_0), 16'(result.key_0));
                    check_field("key_1", 16'(want.key_1), 16'(result.key_1));
                    check_field("key_2", 16'(want.key_2), 16'(result.key_2));
                    check_field("key_3", 16'(want.key_3), 16'(result.key_3));
                    check_field("key_4", 16'(want.key_4), 16'(result.key_4));
                    check_field("key_5", 16'(want.key_5), 16'(result.key_5));
                    check_field("key_count", 16'(want.key_count), 16'(result.key_count));
                    check_field("queue_level", 16'(want.queue_level),
                                16'(result.queue_level));
                end
                if ($urandom_range(0, 49) == 0)
                    stall_on = !stall_on;
                if (received_count > total_items - QUIET_TAIL)
                    stall_on = 1'b0;
            end
            if (hold_gap > 0)
            begin
                hold_gap--;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                if (stall_on && $urandom_range(0, 4) == 0)
                    hold_gap = $urandom_range(1, 7);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        // directed: blocked sends, releases, coalescing limit, zero keys
        add_item(OP_UNUSED, 1'b1, 16'hFFFF);
        add_item(OP_SEND, 1'b0, 16'h0000);
        add_item(OP_COMPLETE, 1'b0, 16'h0000);
        add_item(OP_ENQUEUE, KIND_CONSUMER, 16'hFFFF);
        add_item(OP_SEND, 1'b0, 16'h0000);
        add_item(OP_SEND, 1'b1, 16'hFFFF);
        add_item(OP_COMPLETE, 1'b1, 16'hFFFF);
        add_item(OP_SEND, 1'b0, 16'h0000);
        add_item(OP_COMPLETE, 1'b0, 16'h0000);
        add_item(OP_ENQUEUE, KIND_KEYBOARD, 16'hFF04);
        for (int k = 5; k <= 10; k++)
            add_item(OP_ENQUEUE, KIND_KEYBOARD, 16'(k));
        add_send_complete(3);
        add_item(OP_ENQUEUE, KIND_KEYBOARD, 16'h00FF);
        add_item(OP_ENQUEUE, KIND_KEYBOARD, 16'h0100);
        add_item(OP_SEND, 1'b0, 16'h0000);

        while (stim_count < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    repeat ($urandom_range(1, 8))
                    begin
                        if ($urandom_range(0, 9) == 0)
                            add_item(OP_ENQUEUE, KIND_CONSUMER, 16'($urandom));
                        add_item(OP_ENQUEUE, KIND_KEYBOARD, key_value());
                    end
                    add_send_complete($urandom_range(1, 4));
                end
                4, 5:
                begin
                    add_item(OP_ENQUEUE, KIND_CONSUMER,
                             ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom));
                    add_send_complete(2);
                end
                6:
                begin
                    repeat ($urandom_range(12, 20))
                    begin
                        if ($urandom_range(0, 1) == 0)
                            add_item(OP_ENQUEUE, KIND_KEYBOARD, key_value());
                        else
                            add_item(OP_ENQUEUE, KIND_CONSUMER, 16'($urandom));
                    end
                    add_send_complete($urandom_range(1, 3));
                end
                default:
                    repeat ($urandom_range(1, 4))
                        add_item(2'($urandom_range(0, 3)), 1'($urandom), 16'($urandom));
            endcase
        end
        total_items = pending_requests.size();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        while (accepted_count < total_items)
            @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
